@@ hdl/b36enc_pkg.sv @@
// b36enc_pkg: constants, types and helper functions for the base-36 encoder
// used by b36enc_div_step and base36_integer_encoder_top; no dependencies
`default_nettype none
package b36enc_pkg;

    localparam int unsigned RADIX       = 36;
    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned DIGIT_W     = 6;
    localparam int unsigned CHAR_W      = 7;
    localparam int unsigned STORE_DEPTH = 13;
    localparam int unsigned CNT_W       = 4;
    localparam int unsigned CHUNK_W     = 16;
    localparam int unsigned CHUNKS      = VALUE_W / CHUNK_W;
    localparam int unsigned STEP_W      = 2;

    // partial dividend {rem, chunk} and its reciprocal multiply
    localparam int unsigned PART_W      = DIGIT_W + CHUNK_W;
    localparam int unsigned RECIP_SHIFT = 27;
    localparam int unsigned RECIP_W     = 22;
    localparam logic [RECIP_W-1:0] RECIP_36 = 22'd3728271;
    localparam int unsigned PROD_W      = PART_W + RECIP_W;

    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 7'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_A_BIAS = 7'd55;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [CHAR_W-1:0]  t_char;

    // digit 0..35 to ascii '0'-'9', 'A'-'Z'
    function automatic t_char digit_to_char(input t_digit d);
        t_char c;
        if (d < DEC_DIGITS) begin
            c = CHAR_ZERO + {1'b0, d};
        end else if (d < DIGIT_W'(RADIX)) begin
            c = CHAR_A_BIAS + {1'b0, d};
        end else begin
            c = CHAR_ZERO;
        end
        return c;
    endfunction

endpackage : b36enc_pkg
`default_nettype wire

@@ hdl/b36enc_div_step.sv @@
// b36enc_div_step: one long-division step by 36 over a 16-bit chunk
// depends on b36enc_pkg
`default_nettype none
module b36enc_div_step
    import b36enc_pkg::*;
(
    input  wire logic [DIGIT_W-1:0] i_rem,
    input  wire logic [CHUNK_W-1:0] i_chunk,
    output logic      [CHUNK_W-1:0] o_quot,
    output logic      [DIGIT_W-1:0] o_rem
);

    logic [PART_W-1:0] part;
    logic [PROD_W-1:0] prod;
    logic [PART_W-1:0] back;
    logic [PART_W-1:0] diff;

    // i_rem < 36 so part < 36 * 2^16 and the quotient fits in a chunk;
    // the reciprocal is exact over that range
    assign part   = {i_rem, i_chunk};
    assign prod   = PROD_W'(part) * PROD_W'(RECIP_36);
    assign o_quot = prod[RECIP_SHIFT +: CHUNK_W];
    assign back   = PART_W'(o_quot) * PART_W'(RADIX);
    assign diff   = part - back;
    assign o_rem  = diff[DIGIT_W-1:0];

endmodule : b36enc_div_step
`default_nettype wire

@@ hdl/base36_integer_encoder_top.sv @@
// base36_integer_encoder_top: signed 64-bit integer to base-36 ascii text
// depends on b36enc_pkg and b36enc_div_step
// operation: the n digits (1..13) are found one by one through the shared
//   divide-by-36 unit, one 16-bit chunk per cycle; then one character per
//   cycle is sent, a leading '-' for a negative value and then the digits;
//   busy stays high from acceptance until the last character is strobed
// a new value is taken only once busy is low again
// the receiver cannot stall; i_rst_n is synchronous active low and clears
//   the sequencer and the strobe; digit storage is not cleared
`default_nettype none
module base36_integer_encoder_top
    import b36enc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [VALUE_W-1:0] i_value,
    output logic                    o_strobe,
    output logic [CHAR_W-1:0]       o_out_char,
    output logic                    o_is_last
);

    // sequencer state codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [VALUE_W-1:0]  r_work, n_work;     // dividend, shifts quotient in
    logic [DIGIT_W-1:0]  r_rem, n_rem;       // running remainder
    logic [STEP_W-1:0]   r_step, n_step;     // chunk counter within a digit
    logic [CNT_W-1:0]    r_cnt, n_cnt;       // digits held
    logic                r_neg, n_neg;       // '-' still to send
    logic                r_strobe, n_strobe;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic                r_last, n_last;

    // digit store, least significant first
    logic [DIGIT_W-1:0]  r_store [STORE_DEPTH];

    logic                accept;
    logic [VALUE_W-1:0]  magnitude;
    logic [CHUNK_W-1:0]  step_quot;
    logic [DIGIT_W-1:0]  step_rem;
    logic                store_we;
    logic [CNT_W-1:0]    rd_idx;
    logic [VALUE_W-1:0]  next_work;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // two's complement magnitude; the most negative value maps to 2^63
    assign magnitude = i_value[VALUE_W-1] ? (~i_value + VALUE_W'(1)) : i_value;

    // shared divide unit works on the top chunk of the dividend
    b36enc_div_step u_div (
        .i_rem   (r_rem),
        .i_chunk (r_work[VALUE_W-1 -: CHUNK_W]),
        .o_quot  (step_quot),
        .o_rem   (step_rem)
    );

    assign next_work = {r_work[VALUE_W-CHUNK_W-1:0], step_quot};
    assign rd_idx    = r_cnt - CNT_W'(1);
    assign store_we  = (r_state == S_DIV) && (r_step == STEP_W'(CHUNKS - 1));

    always_comb begin
        n_state  = r_state;
        n_work   = r_work;
        n_rem    = r_rem;
        n_step   = r_step;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = r_last;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DIV;
                    n_work  = magnitude;
                    n_rem   = '0;
                    n_step  = '0;
                    n_cnt   = '0;
                    n_neg   = i_value[VALUE_W-1];
                end
            end
            S_DIV: begin
                n_work = next_work;
                n_rem  = step_rem;
                n_step = r_step + STEP_W'(1);
                if (store_we) begin
                    // digit done; a zero quotient ends the run
                    n_cnt = r_cnt + CNT_W'(1);
                    n_rem = '0;
                    if (next_work == '0) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                n_strobe = 1'b1;
                if (r_neg) begin
                    n_char = CHAR_MINUS;
                    n_last = 1'b0;
                    n_neg  = 1'b0;
                end else begin
                    n_char = digit_to_char(r_store[rd_idx]);
                    n_last = (r_cnt == CNT_W'(1));
                    n_cnt  = rd_idx;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_cnt    <= '0;
            r_neg    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_cnt    <= n_cnt;
            r_neg    <= n_neg;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_rem  <= n_rem;
        r_char <= n_char;
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_cnt] <= step_rem;
        end
    end

    assign o_strobe   = r_strobe;
    assign o_out_char = r_char;
    assign o_is_last  = r_last;

`ifndef NO_ASSERTIONS
    // a character beat only follows an emit cycle
    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == S_EMIT))
        else $error("strobe without emit cycle");

    // digit count never exceeds the store depth
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(STORE_DEPTH))
        else $error("digit count out of range");

    // an accepted beat starts the divide phase
    a_accept_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DIV))
        else $error("accept did not start division");

    // the last marker ends the run and frees the block
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_last) |-> !busy)
        else $error("busy after last character");
`endif

endmodule : base36_integer_encoder_top
`default_nettype wire

@@ verif/base36_integer_encoder_top_test.sv @@
// testbench for base36_integer_encoder_top: sends signed 64-bit values and checks
// every emitted character and last-char flag against a built-in base-36 encoder
// depends on b36enc_pkg and the encoder rtl
`timescale 1ns / 100ps

import b36enc_pkg::*;

typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
} t_text_beat;

// holds the expected text of every accepted value, oldest character first
class text_scoreboard;
    t_text_beat expected_text[$];
    int         mismatches;
    int         chars_checked;
    const string digit_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

    function new();
        mismatches    = 0;
        chars_checked = 0;
    endfunction

    function int pending();
        return expected_text.size();
    endfunction

    // base-36 text of one accepted value
    function void note_value(logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [DIGIT_W-1:0] digits [STORE_DEPTH];
        int                 n;
        t_text_beat         b;
        mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
        n = 0;
        if (mag == '0) begin
            digits[0] = '0;
            n = 1;
        end else begin
            while (mag != '0 && n < STORE_DEPTH) begin
                digits[n] = DIGIT_W'(mag % RADIX);
                mag = mag / RADIX;
                n++;
            end
        end
        if (v[VALUE_W-1]) begin
            b.ch = CHAR_MINUS;
            b.last = 1'b0;
            expected_text.insert(expected_text.size(), b);
        end
        for (int i = n - 1; i >= 0; i--) begin
            b.ch = CHAR_W'(digit_set[digits[i]]);
            b.last = (i == 0);
            expected_text.insert(expected_text.size(), b);
        end
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic last);
        t_text_beat exp_beat;
        chars_checked++;
        if (expected_text.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected char 0x%02h last=%0b", $realtime, ch, last);
            return;
        end
        exp_beat = expected_text.pop_front();
        if (ch !== exp_beat.ch || last !== exp_beat.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: char exp 0x%02h last=%0b, got 0x%02h last=%0b",
                         $realtime, exp_beat.ch, exp_beat.last, ch, last);
        end
    endfunction
endclass

module base36_integer_encoder_top_test;

    localparam int IDLE_LIMIT  = 1000;  // cycles with no beat on either side
    localparam int RANDOM_VALS = 300;
    localparam int DRAIN_WAIT  = 80;    // a little over the longest busy period

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [VALUE_W-1:0] i_value;
    logic               o_strobe;
    logic [CHAR_W-1:0]  o_out_char;
    logic               o_is_last;

    text_scoreboard sb;

    // stimulus shaping and run statistics
    bit burst_mode;
    bit hold_until_done;
    int values_sent;
    int negatives_sent;
    int zeros_sent;
    int idle_cycles;

    base36_integer_encoder_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_value    (i_value),
        .o_strobe   (o_strobe),
        .o_out_char (o_out_char),
        .o_is_last  (o_is_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // every strobed character is checked at the edge that ends its cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_char(o_out_char, o_is_last);
    end

    // watchdog: any accepted input beat or output beat restarts the count
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n && ((start && !busy) || o_strobe))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: %0d cycles with no beat", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // one input beat: optional hold-off, then start stays up until busy is low
    // at a rising edge; inputs only move at falling edges
    task automatic drive_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 13);
        hold_until_done = !burst_mode && ($urandom_range(0, 1) == 1);
        @(negedge i_clk);
        if (gap != 0 || (hold_until_done && busy)) begin
            start = 1'b0;
            // sometimes count the gap from the end of the current value
            if (hold_until_done)
                while (busy) @(negedge i_clk);
            repeat (gap) @(negedge i_clk);
        end
        start   = 1'b1;
        i_value = v;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_value(v);
        values_sent++;
        if (v[VALUE_W-1]) negatives_sent++;
        if (v == '0) zeros_sent++;
    endtask

    // random value with a spread of digit counts and both signs
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: ;                                        // full width, either sign
            1, 2: v = v >> $urandom_range(1, 63);      // shorter magnitudes
            default: v = VALUE_W'($urandom_range(0, 1500));
        endcase
        if ($urandom_range(0, 3) != 0 && $urandom_range(0, 1) == 1)
            v = ~v + 1'b1;
        return v;
    endfunction

    initial begin
        logic [VALUE_W-1:0] directed [$];
        sb = new();
        values_sent = 0;
        negatives_sent = 0;
        zeros_sent = 0;
        burst_mode = 1'b0;
        hold_until_done = 1'b0;
        start   = 1'b0;
        i_value = '0;
        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero, single digits on both sides of the letter switch, radix edges,
        // both ends of the range (most negative needs magnitude 2^63), the
        // 13-digit boundary and alternating bit patterns
        directed = '{
            64'd0, 64'd1, -64'd1, 64'd9, 64'd10, 64'd35, -64'd35,
            64'd36, -64'd36, 64'd37, 64'd1295, 64'd1296,
            64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
            64'h8000_0000_0000_0001,
            64'd4738381338321616895, 64'd4738381338321616896,
            -64'd4738381338321616896,
            64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA
        };
        // first half back to back, rest with random hold-offs
        foreach (directed[i]) begin
            burst_mode = (i < directed.size() / 2);
            drive_value(directed[i]);
        end

        // random part in stretches, some with no idling at all
        for (int i = 0; i < RANDOM_VALS; i++) begin
            if (i % 25 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            drive_value(random_value());
        end
        @(negedge i_clk);
        start = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sent %0d values (%0d negative, %0d zero), checked %0d characters",
                 values_sent, negatives_sent, zeros_sent, sb.chars_checked);
        $display("mismatches: %0d, characters still expected: %0d",
                 sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
